// ===== rtl/core/kirsch_pkg.sv =====
// Shared types and constants for the Kirsch compass edge detector core.
// No dependencies; imported by every module of the core except kirsch_ram.
`timescale 1ns / 1ps

package kirsch_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    // Defaults
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int FIFO_DEPTH    = 8;

    localparam logic [IMG_W_W-1:0] IMG_WIDTH_RST  = 11'd1024;
    localparam logic [IMG_H_W-1:0] IMG_HEIGHT_RST = 12'd768;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // 3x3 window, indexed [row][col], row 0 is the oldest line
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    // Position info that travels with each result
    typedef struct packed {
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        tag_t             tag;
    } result_t;

endpackage

// ===== rtl/core/kirsch_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old contents.
`timescale 1ns / 1ps

module kirsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/kirsch_window.sv =====
// Raster position tracking, two-line store (read-modify-write) and 3x3 window.
// Depends on kirsch_pkg and kirsch_ram.
`timescale 1ns / 1ps

module kirsch_window import kirsch_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [IMG_W_W-1:0] image_width,
    input  logic [IMG_H_W-1:0] image_height,
    input  logic               in_fire,
    input  logic [PIX_W-1:0]   in_pixel,
    input  logic               in_frame_start,
    output logic               in_emit,
    output logic               win_valid,
    output tag_t               win_tag,
    output window_t            win_pixels
);

    // Position of the next pixel
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Stage 1: line store read in flight
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic [CW-1:0]    s1_addr_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    tag_t             s1_tag_reg;

    // Last write, for same-address forwarding
    logic             fwd_valid_reg;
    logic [CW-1:0]    fwd_addr_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;

    // Stage 2: window holds the item
    window_t win_reg, win_next;
    logic    win_valid_reg;
    tag_t    win_tag_reg;

    logic [WW-1:0]      iw_ext, eff_w, col_inc;
    logic [IMG_H_W-1:0] eff_h;
    logic [CW-1:0]      col_base, cur_col, cur_col_m1;
    logic [ROW_W-1:0]   row_base, cur_row;
    logic [ROW_W:0]     row_pre, row_inc;
    logic               col_wrap, end_of_row;
    tag_t               cur_tag;

    logic [2*PIX_W-1:0] ram_rd_data, line_word, ram_wr_data;
    logic [PIX_W-1:0]   up1, up2;
    logic               fwd_hit;

    // Effective frame size
    always_comb begin
        iw_ext = WW'(image_width);
        if (iw_ext < WW'(3)) begin
            eff_w = WW'(3);
        end else if (iw_ext > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = iw_ext;
        end
        eff_h = (image_height < IMG_H_W'(3)) ? IMG_H_W'(3) : image_height;
    end

    // Position of the incoming pixel, wrapping counters past the frame size
    always_comb begin
        col_base = in_frame_start ? '0 : col_reg;
        row_base = in_frame_start ? '0 : row_reg;
        col_wrap = (WW'(col_base) >= eff_w);
        row_pre  = col_wrap ? ({1'b0, row_base} + (ROW_W+1)'(1)) : {1'b0, row_base};
        cur_row  = (row_pre >= {1'b0, eff_h}) ? '0 : row_pre[ROW_W-1:0];
        cur_col  = col_wrap ? '0 : col_base;

        col_inc    = WW'(cur_col) + WW'(1);
        end_of_row = (col_inc >= eff_w);
        row_inc    = {1'b0, cur_row} + (ROW_W+1)'(1);
        if (end_of_row) begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            col_next = col_inc[CW-1:0];
            row_next = cur_row;
        end

        in_emit    = (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));
        cur_col_m1 = cur_col - CW'(1);
        cur_tag.center_row = cur_row - ROW_W'(1);
        cur_tag.center_col = COL_W'(cur_col_m1);
        cur_tag.last       = (cur_row == eff_h - IMG_H_W'(1)) && end_of_row;
    end

    // Counters and stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg  <= in_fire;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_emit_reg  <= in_emit;
            s1_addr_reg  <= cur_col;
            s1_pixel_reg <= in_pixel;
            s1_tag_reg   <= cur_tag;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= ram_wr_data;
    end

    // Line store: word = {row r-1, row r-2} at each column
    kirsch_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (in_fire),
        .rd_addr (cur_col),
        .rd_data (ram_rd_data)
    );

    // Forward the previous cycle's write when it hit the address just read
    always_comb begin
        fwd_hit     = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);
        line_word   = fwd_hit ? fwd_data_reg : ram_rd_data;
        up2         = line_word[PIX_W-1:0];
        up1         = line_word[2*PIX_W-1:PIX_W];
        ram_wr_data = {s1_pixel_reg, up1};
    end

    // Window shift
    always_comb begin
        win_next = win_reg;
        if (s1_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = up2;
            win_next[1][2] = up1;
            win_next[2][2] = s1_pixel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg       <= '0;
            win_valid_reg <= 1'b0;
        end else begin
            win_reg       <= win_next;
            win_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        win_tag_reg <= s1_tag_reg;
    end

    assign win_valid  = win_valid_reg;
    assign win_tag    = win_tag_reg;
    assign win_pixels = win_reg;

endmodule

// ===== rtl/core/kirsch_compass.sv =====
// Eight Kirsch compass sums over the window, maximum, floor, scale and clamp.
// Three register stages; depends on kirsch_pkg.
`timescale 1ns / 1ps

module kirsch_compass import kirsch_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  tag_t    in_tag,
    input  window_t in_window,
    output logic    res_valid,
    output result_t res
);

    localparam int THREE_W = PIX_W + 2;   // sum of three pixels
    localparam int TOT_W   = PIX_W + 3;   // sum of eight pixels
    localparam int TOT3_W  = TOT_W + 2;   // three times that
    localparam int SUM_W   = THREE_W + 4; // signed mask response
    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    logic [PIX_W-1:0]   ring [8];
    logic [TOT_W-1:0]   total;
    logic [THREE_W-1:0] three [8];

    logic                     a_valid_reg, b_valid_reg, res_valid_reg;
    tag_t                     a_tag_reg, b_tag_reg;
    logic [THREE_W-1:0]       three_reg [8];
    logic [TOT3_W-1:0]        tot3_reg;
    logic signed [SUM_W-1:0]  sum [8];
    logic signed [SUM_W-1:0]  sum_reg [8];
    logic signed [SUM_W-1:0]  lvl1 [4];
    logic signed [SUM_W-1:0]  lvl2 [2];
    logic signed [SUM_W-1:0]  top;
    logic [SUM_W-2:0]         best;
    logic [SUM_W-5:0]         scaled;
    result_t                  res_reg;
    logic [PIX_W-1:0]         edge_value;

    // Neighbor ring, counter-clockwise from top right
    always_comb begin
        ring[0] = in_window[0][2];
        ring[1] = in_window[0][1];
        ring[2] = in_window[0][0];
        ring[3] = in_window[1][0];
        ring[4] = in_window[2][0];
        ring[5] = in_window[2][1];
        ring[6] = in_window[2][2];
        ring[7] = in_window[1][2];
        total = '0;
        for (int m = 0; m < 8; m++) begin
            total = total + TOT_W'(ring[m]);
        end
        for (int m = 0; m < 8; m++) begin
            three[m] = THREE_W'(ring[m]) + THREE_W'(ring[(m + 1) & 7])
                     + THREE_W'(ring[(m + 2) & 7]);
        end
    end

    // Mask response: 8*three - 3*total
    always_comb begin
        for (int m = 0; m < 8; m++) begin
            sum[m] = $signed({1'b0, three_reg[m], 3'b000}) - $signed({1'b0, tot3_reg});
        end
    end

    // Maximum tree, floor at zero, divide by eight, clamp
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            lvl1[k] = (sum_reg[2*k] > sum_reg[2*k+1]) ? sum_reg[2*k] : sum_reg[2*k+1];
        end
        for (int k = 0; k < 2; k++) begin
            lvl2[k] = (lvl1[2*k] > lvl1[2*k+1]) ? lvl1[2*k] : lvl1[2*k+1];
        end
        top        = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
        best       = top[SUM_W-1] ? '0 : top[SUM_W-2:0];
        scaled     = best[SUM_W-2:3];
        edge_value = (scaled > (SUM_W-4)'(EDGE_MAX)) ? EDGE_MAX : scaled[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            res_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        three_reg <= three;
        tot3_reg  <= {total, 1'b0} + TOT3_W'(total);
        a_tag_reg <= in_tag;
        sum_reg   <= sum;
        b_tag_reg <= a_tag_reg;
        res_reg.edge_value <= edge_value;
        res_reg.tag        <= b_tag_reg;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/core/kirsch_out_fifo.sv =====
// Small result queue that decouples the fixed-latency pipe from output stalls.
// Depends on kirsch_pkg; the producer never pushes into a full queue.
`timescale 1ns / 1ps

module kirsch_out_fifo import kirsch_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    not_empty,
    output result_t head
);

    result_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/kirsch_edge_detector_core.sv =====
// Kirsch 3x3 compass edge detector, streaming one pixel plane in raster order.
// Each result passes the line store read, the window, the compass stages and the output queue in turn.
// Throughput: 1 pixel per cycle while s_ready is high; the line store does one read and one write per cycle.
// Reset clears position counters, window, queue and credit count, and sets the size registers to 1024 x 768;
// the line store is not cleared and is filled by the first two rows of a frame.
`timescale 1ns / 1ps

module kirsch_edge_detector_core import kirsch_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_edge_value,
    output logic [ROW_W-1:0]      m_center_row,
    output logic [COL_W-1:0]      m_center_col,
    output logic                  m_last
);

    localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [PEND_W-1:0]  pending_reg, pending_next;

    logic    s_fire, m_fire, in_emit;
    logic    win_valid;
    tag_t    win_tag;
    window_t win_pixels;
    logic    res_valid;
    result_t res, head;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMG_WIDTH_RST;
            image_height_reg <= IMG_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // Results owed: in the pipe or waiting in the queue
    always_comb begin
        pending_next = pending_reg + PEND_W'(s_fire && in_emit) - PEND_W'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    assign s_ready = (pending_reg < PEND_W'(FIFO_DEPTH));

    kirsch_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .image_width    (image_width_reg),
        .image_height   (image_height_reg),
        .in_fire        (s_fire),
        .in_pixel       (s_pixel),
        .in_frame_start (s_frame_start),
        .in_emit        (in_emit),
        .win_valid      (win_valid),
        .win_tag        (win_tag),
        .win_pixels     (win_pixels)
    );

    kirsch_compass u_compass (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_tag    (win_tag),
        .in_window (win_pixels),
        .res_valid (res_valid),
        .res       (res)
    );

    kirsch_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_fire),
        .not_empty (m_valid),
        .head      (head)
    );

    assign m_edge_value = head.edge_value;
    assign m_center_row = head.tag.center_row;
    assign m_center_col = head.tag.center_col;
    assign m_last       = head.tag.last;

    // Credit count never exceeds queue space
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PEND_W'(FIFO_DEPTH))
        else $error("pending result count above queue depth");

    // A visible result must be covered by an outstanding credit
    a_result_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != '0))
        else $error("result shown with no credit outstanding");

    // Results only come from interior centers, never row zero
    a_interior_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_center_row != '0))
        else $error("result for a border row");

    // No accept at full credit; a pop without a fresh emit frees space
    a_credit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && !(s_fire && in_emit)) |=> (pending_reg < PEND_W'(FIFO_DEPTH)))
        else $error("credit not returned on output transfer");

endmodule
